// ===== src/qpt_pkg.sv =====
// Shared types and constants for the quadrature position tracker.
`default_nettype none

package qpt_pkg;

  localparam int POS_W   = 16;
  localparam int CNT_W   = 18;
  localparam int FUNC_W  = 2;
  localparam int SENS_W  = 2;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int REG_IDX_W = 3;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CENTER = 2'd2;

  // Register indexes (byte address = 4 * index).
  localparam logic [REG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SENS   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CENTER = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LOWER  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_UPPER  = 3'd4;

  // Register reset values.
  localparam logic [SENS_W-1:0] SENS_RESET  = 2'd1;
  localparam logic [POS_W-1:0]  UPPER_RESET = 16'd255;

  // Step count saturation bounds.
  localparam logic [CNT_W-1:0] CNT_MAX = 18'h1FFFF;
  localparam logic [CNT_W-1:0] CNT_MIN = 18'h20000;

  typedef struct packed {
    logic              enable;
    logic [SENS_W-1:0] sensitivity;
    logic [POS_W-1:0]  center_position;
    logic [POS_W-1:0]  lower_limit;
    logic [POS_W-1:0]  upper_limit;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              pin_a;
    logic              pin_b;
    logic [POS_W-1:0]  new_position;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             moved;
    logic             clamped;
  } res_t;

endpackage

`default_nettype wire

// ===== src/qpt_regs.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none

module qpt_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [qpt_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [qpt_pkg::DATA_W-1:0]  pwdata,
  output logic      [qpt_pkg::DATA_W-1:0]  prdata,
  output qpt_pkg::cfg_t                    cfg
);
  import qpt_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx   = paddr[ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_ENABLE: cfg_nxt.enable          = pwdata[0];
        REG_SENS:   cfg_nxt.sensitivity     = pwdata[SENS_W-1:0];
        REG_CENTER: cfg_nxt.center_position = pwdata[POS_W-1:0];
        REG_LOWER:  cfg_nxt.lower_limit     = pwdata[POS_W-1:0];
        REG_UPPER:  cfg_nxt.upper_limit     = pwdata[POS_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable          <= 1'b0;
      cfg_r.sensitivity     <= SENS_RESET;
      cfg_r.center_position <= '0;
      cfg_r.lower_limit     <= '0;
      cfg_r.upper_limit     <= UPPER_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE: prdata = {{(DATA_W-1){1'b0}}, cfg_r.enable};
      REG_SENS:   prdata = {{(DATA_W-SENS_W){1'b0}}, cfg_r.sensitivity};
      REG_CENTER: prdata = {{(DATA_W-POS_W){cfg_r.center_position[POS_W-1]}},
                            cfg_r.center_position};
      REG_LOWER:  prdata = {{(DATA_W-POS_W){cfg_r.lower_limit[POS_W-1]}},
                            cfg_r.lower_limit};
      REG_UPPER:  prdata = {{(DATA_W-POS_W){cfg_r.upper_limit[POS_W-1]}},
                            cfg_r.upper_limit};
      default:    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== src/qpt_core.sv =====
// Tracker state and the single-pass step, divide and clamp logic.
`default_nettype none

module qpt_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          advance,
  input  qpt_pkg::req_t      req,
  input  qpt_pkg::cfg_t      cfg,
  output qpt_pkg::res_t      res
);
  import qpt_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             last_a_r, last_a_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic             div_one;
  logic [CNT_W-1:0] step_cnt;
  logic [CNT_W:0]   step_sum;
  logic [CNT_W-1:0] half_cnt;
  logic [CNT_W-1:0] load_val;
  logic [CNT_W-1:0] pos_w;
  logic [CNT_W-1:0] cnt_w;
  logic [CNT_W-1:0] lower_w;
  logic [CNT_W-1:0] upper_w;
  logic             moved;
  logic             clamped;

  // Count and position agree as count = position * divisor.
  function automatic logic [CNT_W-1:0] load_count(input logic [POS_W-1:0] p,
                                                  input logic one);
    logic [CNT_W-1:0] ext;
    ext = {{(CNT_W-POS_W){p[POS_W-1]}}, p};
    return one ? ext : {ext[CNT_W-2:0], 1'b0};
  endfunction

  assign div_one = cfg.sensitivity[1];
  assign lower_w = {{(CNT_W-POS_W){cfg.lower_limit[POS_W-1]}}, cfg.lower_limit};
  assign upper_w = {{(CNT_W-POS_W){cfg.upper_limit[POS_W-1]}}, cfg.upper_limit};

  // Step the count by one, saturating at its range.
  assign step_sum = {count_r[CNT_W-1], count_r} +
                    ((req.pin_b != req.pin_a) ? {{CNT_W{1'b0}}, 1'b1} : {(CNT_W+1){1'b1}});
  always_comb begin
    if (step_sum[CNT_W] != step_sum[CNT_W-1]) begin
      step_cnt = step_sum[CNT_W] ? CNT_MIN : CNT_MAX;
    end else begin
      step_cnt = step_sum[CNT_W-1:0];
    end
  end

  // Halve toward zero: bias negatives by one before the arithmetic shift.
  assign half_cnt = $unsigned($signed(step_cnt + {{(CNT_W-1){1'b0}}, step_cnt[CNT_W-1]}) >>> 1);

  always_comb begin
    pos_w      = {{(CNT_W-POS_W){pos_r[POS_W-1]}}, pos_r};
    cnt_w      = count_r;
    last_a_nxt = last_a_r;
    moved      = 1'b0;
    clamped    = 1'b0;
    load_val   = '0;
    case (req.func)
      FUNC_SAMPLE: begin
        if (cfg.enable) begin
          if (req.pin_a != last_a_r) begin
            cnt_w = step_cnt;
            pos_w = div_one ? step_cnt : half_cnt;
          end
          last_a_nxt = req.pin_a;
          moved      = 1'b1;
        end
      end
      FUNC_SET: begin
        pos_w = {{(CNT_W-POS_W){req.new_position[POS_W-1]}}, req.new_position};
        cnt_w = load_count(req.new_position, div_one);
      end
      FUNC_CENTER: begin
        pos_w = {{(CNT_W-POS_W){cfg.center_position[POS_W-1]}}, cfg.center_position};
        cnt_w = load_count(cfg.center_position, div_one);
      end
      default: begin
        pos_w = pos_w;
      end
    endcase

    // Clamp, lower limit first: with crossed limits, below lower goes to lower, else to upper.
    if ($signed(pos_w) < $signed(lower_w)) begin
      pos_w   = lower_w;
      cnt_w   = load_count(cfg.lower_limit, div_one);
      clamped = 1'b1;
      moved   = 1'b0;
    end else if ($signed(pos_w) > $signed(upper_w)) begin
      pos_w   = upper_w;
      cnt_w   = load_count(cfg.upper_limit, div_one);
      clamped = 1'b1;
      moved   = 1'b0;
    end
    load_val  = cnt_w;
    count_nxt = load_val;
    pos_nxt   = pos_w[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      last_a_r <= 1'b0;
      pos_r    <= '0;
    end else if (advance) begin
      count_r  <= count_nxt;
      last_a_r <= last_a_nxt;
      pos_r    <= pos_nxt;
    end
  end

  assign res.position = pos_nxt;
  assign res.moved    = moved;
  assign res.clamped  = clamped;

endmodule

`default_nettype wire

// ===== src/quadrature_position_tracker_unit.sv =====
// Top level of the quadrature position tracker.
//
// Usage:
//   Requests arrive on the in_ channel (valid/ready): a pin sample of encoder
//   channels A and B, a set-position command or a recenter command. Every
//   request produces exactly one result on the out_ channel: the clamped
//   position plus moved and clamped flags.
//   Configuration goes through the cfg_ APB-style port: enable (0x00),
//   sensitivity (0x04), center position (0x08), lower limit (0x0C) and upper
//   limit (0x10). Write it only while no request is in flight.
// Timing:
//   A request accepted at a clock edge is registered in the input register,
//   processed in one pass and registered into the result register on out_.
//   Throughput is one request per cycle while out_ready stays high; the limit
//   is the update of the step count register, which feeds the next request.
// Reset and stall:
//   Synchronous active-low reset zeroes the count, last A level and position,
//   and loads the register defaults (disabled, two steps per position,
//   limits 0 and 255). When the receiver holds out_ready low the result holds;
//   one more request can sit in the input register, then in_ready drops.
`default_nettype none

module quadrature_position_tracker_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Request channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [qpt_pkg::FUNC_W-1:0]  in_func,
  input  wire logic                        in_pin_a,
  input  wire logic                        in_pin_b,
  input  wire logic [qpt_pkg::POS_W-1:0]   in_new_position,
  // Result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [qpt_pkg::POS_W-1:0]   out_position,
  output logic                             out_moved,
  output logic                             out_clamped,
  // Configuration port
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [qpt_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire logic [qpt_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic      [qpt_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import qpt_pkg::*;

  cfg_t cfg;
  req_t req_r;
  res_t res_c;
  res_t res_r;
  logic in_valid_r, in_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic advance;

  qpt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign cfg_pready = 1'b1;

  // Advance the held request when the result register is free or drains now.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end

    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the request payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.func         <= in_func;
      req_r.pin_a        <= in_pin_a;
      req_r.pin_b        <= in_pin_b;
      req_r.new_position <= in_new_position;
    end
  end

  qpt_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .req     (req_r),
    .cfg     (cfg),
    .res     (res_c)
  );

  // Hold the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_c;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_position = res_r.position;
  assign out_moved    = res_r.moved;
  assign out_clamped  = res_r.clamped;

endmodule

`default_nettype wire

// ===== src/qpt_checker.sv =====
// Port-level checker for the quadrature position tracker, bound to the top level.
`default_nettype none

module qpt_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [qpt_pkg::POS_W-1:0] out_position,
  input wire logic                      out_moved,
  input wire logic                      out_clamped
);

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position) &&
                                $stable(out_moved) && $stable(out_clamped))
    else $error("stalled result changed");

  // A clamp always clears the moved flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_moved && out_clamped))
    else $error("moved and clamped both set");

  // Backpressure only comes from a stalled, full result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // Reset empties the result register.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind quadrature_position_tracker_unit qpt_checker u_qpt_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the quadrature position tracker unit.
`timescale 1ns / 1ps

module tb_top;
  import qpt_pkg::*;

  // Code 3 is not decoded by the block: the request only runs the limit clamp.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int MAX_SHOWN = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Request channel. Drive the payload from one struct so it moves as a unit.
  logic in_valid = 1'b0;
  logic in_ready;
  req_t drive_req = '0;

  // Result channel.
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [POS_W-1:0]  out_position;
  logic              out_moved;
  logic              out_clamped;

  // Configuration port.
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  quadrature_position_tracker_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (drive_req.func),
    .in_pin_a        (drive_req.pin_a),
    .in_pin_b        (drive_req.pin_b),
    .in_new_position (drive_req.new_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_position    (out_position),
    .out_moved       (out_moved),
    .out_clamped     (out_clamped),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Requests waiting to be driven, and results predicted for accepted requests.
  req_t request_q[$];
  res_t position_expect_q[$];

  // Percent of cycles in which the sender holds off and the receiver stalls.
  int send_idle_pct = 12;
  int recv_idle_pct = 60;

  logic request_taken = 1'b0;
  int   err_count = 0;
  int   result_idx = 0;

  // Mirror of the configuration registers, updated as each write lands.
  logic                    mir_enable = 1'b0;
  logic [SENS_W-1:0]       mir_sens = SENS_RESET;
  logic signed [POS_W-1:0] mir_center = '0;
  logic signed [POS_W-1:0] mir_lower = '0;
  logic signed [POS_W-1:0] mir_upper = UPPER_RESET;

  // Predicted tracker state.
  logic signed [CNT_W-1:0] trk_count = '0;
  logic                    trk_last_a = 1'b0;
  logic signed [POS_W-1:0] trk_position = '0;

  // Quadrature walk used to build well-formed pin sequences.
  logic [1:0] walk_phase = 2'd0;
  logic       walk_up = 1'b1;

  function automatic logic signed [CNT_W-1:0] sat_count(input int c);
    if (c > int'($signed(CNT_MAX))) return CNT_MAX;
    if (c < int'($signed(CNT_MIN))) return CNT_MIN;
    return CNT_W'(c);
  endfunction

  // Advance the predicted tracker by one request and return its result.
  // Keep the unclamped position in a full int: with one step per position it
  // can run one past the 16-bit range before the clamp pulls it back.
  function automatic res_t track_position(input req_t r);
    res_t res;
    int   div;
    int   p;
    res = '0;
    div = mir_sens[1] ? 1 : 2;
    p = int'(trk_position);
    case (r.func)
      FUNC_SAMPLE: begin
        if (mir_enable) begin
          if (r.pin_a != trk_last_a) begin
            // Step up when A leads B, down otherwise; truncate toward zero.
            trk_count = sat_count(int'(trk_count) + ((r.pin_b != r.pin_a) ? 1 : -1));
            p = int'(trk_count) / div;
          end
          trk_last_a = r.pin_a;
          res.moved = 1'b1;
        end
      end
      FUNC_SET: begin
        p = int'($signed(r.new_position));
        trk_count = sat_count(p * div);
      end
      FUNC_CENTER: begin
        p = int'(mir_center);
        trk_count = sat_count(p * div);
      end
      default: ;
    endcase
    // Check the lower limit first so crossed limits resolve the same way.
    if (p < int'(mir_lower)) begin
      p = int'(mir_lower);
      trk_count = sat_count(p * div);
      res.clamped = 1'b1;
      res.moved = 1'b0;
    end else if (p > int'(mir_upper)) begin
      p = int'(mir_upper);
      trk_count = sat_count(p * div);
      res.clamped = 1'b1;
      res.moved = 1'b0;
    end
    trk_position = POS_W'(p);
    res.position = trk_position;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_SHOWN)
      $display("ERROR at %0t, result %0d: %s", $time, result_idx, what);
  endtask

  // Driver: change inputs on the falling edge. Hold a request until taken,
  // then either present the next one or idle.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || request_taken) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_req <= request_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: sample both handshakes on the rising edge. Predict first so a
  // result leaving in the same cycle still finds its expectation.
  always @(posedge clk) begin
    request_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready)
        position_expect_q.push_back(track_position(drive_req));
      if (out_valid && out_ready) begin
        if (position_expect_q.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          res_t want;
          want = position_expect_q.pop_front();
          if (out_position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      $signed(out_position), $signed(want.position)));
          if (out_moved !== want.moved)
            report_mismatch($sformatf("moved %b, expected %b", out_moved, want.moved));
          if (out_clamped !== want.clamped)
            report_mismatch($sformatf("clamped %b, expected %b", out_clamped, want.clamped));
        end
        result_idx++;
      end
    end
  end

  task automatic push_request(input logic [FUNC_W-1:0] f, input logic a, input logic b,
                              input logic [POS_W-1:0] p);
    req_t r;
    r.func = f;
    r.pin_a = a;
    r.pin_b = b;
    r.new_position = p;
    request_q.push_back(r);
  endtask

  // Setup cycle, then access cycle; the register lands on the edge with
  // psel, penable, pwrite and pready all high.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_ENABLE: mir_enable = data[0];
      REG_SENS:   mir_sens = data[SENS_W-1:0];
      REG_CENTER: mir_center = data[POS_W-1:0];
      REG_LOWER:  mir_lower = data[POS_W-1:0];
      REG_UPPER:  mir_upper = data[POS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic program_tracker(input logic en, input logic [SENS_W-1:0] sens,
                                 input logic [POS_W-1:0] center,
                                 input logic [POS_W-1:0] lower,
                                 input logic [POS_W-1:0] upper);
    write_reg(REG_ENABLE, DATA_W'(en));
    write_reg(REG_SENS, DATA_W'(sens));
    write_reg(REG_CENTER, DATA_W'(center));
    write_reg(REG_LOWER, DATA_W'(lower));
    write_reg(REG_UPPER, DATA_W'(upper));
  endtask

  // Drain: wait until no request is left to drive and every predicted result
  // has been seen.
  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid || position_expect_q.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Mostly quadrature walks with random direction bursts, mixed with stray
  // pin levels, position loads (often close to a limit), recenters and the
  // unused code.
  task automatic queue_random_requests(input int count);
    int roll;
    int near;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 72) begin
        if ($urandom_range(15) == 0) walk_up = !walk_up;
        walk_phase = walk_up ? walk_phase + 2'd1 : walk_phase - 2'd1;
        push_request(FUNC_SAMPLE, walk_phase[0] ^ walk_phase[1], walk_phase[1],
                     POS_W'($urandom));
      end else if (roll < 82) begin
        push_request(FUNC_SAMPLE, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     POS_W'($urandom));
      end else if (roll < 91) begin
        near = ($urandom_range(1) ? int'(mir_lower) : int'(mir_upper))
               + int'($urandom_range(8)) - 4;
        push_request(FUNC_SET, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     $urandom_range(1) ? POS_W'($urandom) : POS_W'(near));
      end else if (roll < 96) begin
        push_request(FUNC_CENTER, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     POS_W'($urandom));
      end else begin
        push_request(FUNC_UNUSED, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     POS_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    logic signed [POS_W-1:0] lim_a;
    logic signed [POS_W-1:0] lim_b;
    logic signed [POS_W-1:0] lo;
    logic signed [POS_W-1:0] hi;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: disabled, two steps per position, limits 0 and 255.
    push_request(FUNC_SAMPLE, 1'b1, 1'b0, '0);
    push_request(FUNC_SET, 1'b0, 1'b0, 16'd300);
    push_request(FUNC_SET, 1'b0, 1'b0, -16'sd5);
    push_request(FUNC_UNUSED, 1'b1, 1'b1, 16'hFFFF);
    push_request(FUNC_CENTER, 1'b0, 1'b0, '0);
    wait_idle();

    // Full range: step past the top and bottom of the position range.
    program_tracker(1'b1, 2'd1, 16'h7FFF, 16'h8000, 16'h7FFF);
    push_request(FUNC_CENTER, 1'b0, 1'b0, '0);
    push_request(FUNC_SAMPLE, 1'b1, 1'b0, '0);
    push_request(FUNC_SAMPLE, 1'b1, 1'b1, '0);
    push_request(FUNC_SAMPLE, 1'b0, 1'b1, '0);
    push_request(FUNC_SET, 1'b0, 1'b0, 16'h8000);
    push_request(FUNC_SAMPLE, 1'b1, 1'b1, '0);
    push_request(FUNC_SAMPLE, 1'b0, 1'b0, '0);
    push_request(FUNC_SET, 1'b1, 1'b0, 16'h5555);
    push_request(FUNC_SET, 1'b0, 1'b1, 16'hAAAA);
    wait_idle();

    // One step per position in a narrow window: walk down into the floor.
    program_tracker(1'b1, 2'd2, -16'sd1, -16'sd3, 16'sd3);
    push_request(FUNC_CENTER, 1'b0, 1'b0, '0);
    push_request(FUNC_SAMPLE, 1'b1, 1'b1, '0);
    push_request(FUNC_SAMPLE, 1'b0, 1'b0, '0);
    push_request(FUNC_SAMPLE, 1'b1, 1'b1, '0);
    wait_idle();

    // Crossed limits: below lower goes to lower, anything else to upper.
    program_tracker(1'b1, 2'd3, 16'd0, 16'd100, 16'd50);
    push_request(FUNC_SET, 1'b0, 1'b0, 16'd20);
    push_request(FUNC_UNUSED, 1'b0, 1'b0, '0);
    push_request(FUNC_SET, 1'b0, 1'b0, 16'd200);
    wait_idle();

    // Divisor from sensitivity 0, samples ignored while disabled.
    program_tracker(1'b0, 2'd0, 16'd0, 16'h8000, 16'h7FFF);
    push_request(FUNC_SAMPLE, 1'b0, 1'b1, '0);
    push_request(FUNC_SET, 1'b0, 1'b0, 16'd1234);
    push_request(FUNC_UNUSED, 1'b1, 1'b0, '0);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      // Sender light and receiver heavy, then swapped, then full rate.
      send_idle_pct = (ph < 3) ? 12 : (ph < 6) ? 60 : 0;
      recv_idle_pct = (ph < 3) ? 60 : (ph < 6) ? 12 : 0;
      lim_a = POS_W'($urandom);
      lim_b = POS_W'($urandom);
      lo = (lim_a < lim_b) ? lim_a : lim_b;
      hi = (lim_a < lim_b) ? lim_b : lim_a;
      case (ph)
        0: program_tracker(1'b1, 2'd1, POS_W'($urandom), 16'h8000, 16'h7FFF);
        1: program_tracker(1'b1, 2'd2, 16'd0, -16'sd200, 16'sd200);
        2: program_tracker(1'b1, SENS_W'($urandom_range(3)), POS_W'($urandom),
                           {1'b1, lo[14:0]}, {1'b0, hi[14:0]});
        3: program_tracker(1'b0, SENS_W'($urandom_range(3)), POS_W'($urandom), lo, hi);
        4: program_tracker(1'b1, 2'd3, POS_W'($urandom), lim_a, lim_a);
        5: program_tracker(1'b1, 2'd0, POS_W'($urandom), hi, lo);
        6: program_tracker(1'b1, 2'd2, 16'h7FFF, 16'd32700, 16'h7FFF);
        7: program_tracker(1'b1, 2'd1, 16'h8000, 16'h8000, -16'sd32700);
        default: program_tracker(1'b1, SENS_W'($urandom_range(3)), POS_W'($urandom),
                                 lo, hi);
      endcase
      queue_random_requests((ph == 3) ? 40 : 125);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (position_expect_q.size() != 0)
      report_mismatch("results never delivered");
    if (err_count == 0) begin
      $display("PASS quadrature_position_tracker_unit");
    end else begin
      $display("FAIL quadrature_position_tracker_unit");
    end
    $finish;
  end

  // Stop a hung run: far beyond the slowest legal run of this stimulus.
  initial begin
    #2_000_000;
    $display("FAIL quadrature_position_tracker_unit");
    $finish;
  end

endmodule
